// ===== rtl/atids_pkg.sv =====
// ----------------------------------------------------------------------------
// atids_pkg: shared types and codes for the array table
// Request and response structs, operation codes, status codes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package atids_pkg;

    localparam int CAPACITY_DEF = 32;

    // operation codes
    localparam logic [2:0] OP_SEARCH = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        [2:0]  operation;
        logic        [5:0]  position;
        logic signed [31:0] key_value;
        logic signed [31:0] replacement;
    } t_req;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [4:0]  found_position;
        logic signed [31:0] read_data;
        logic        [5:0]  entry_count;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/array_table_insert_delete_search.sv =====
// Search scans the entries in order; update and delete use a binary search of at
//   most log2(L)+1 probes (L = entry count); insert and delete shift the entries
//   above the position by one.
// One request at a time: the next is taken only after the response has loaded
//   into the output register.
// Reset: the entry count goes to zero; the table memory is not cleared.
// ----------------------------------------------------------------------------
// array_table_insert_delete_search: bounded table with search/insert/update/delete/read
// Sequenced table of signed words over one memory.
// ----------------------------------------------------------------------------
`default_nettype none

module array_table_insert_delete_search #(
    parameter int CAPACITY = atids_pkg::CAPACITY_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire atids_pkg::t_req i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output atids_pkg::t_rsp  o_out_data
);
    import atids_pkg::*;

    // index into the table, entry count, and a width that holds index + 2
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int XW   = AW + 1;
    localparam int CMPW = (LW > 6) ? LW : 6;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LIN     = 4'd1;
    localparam logic [3:0] S_INS_MV  = 4'd2;
    localparam logic [3:0] S_INS_KEY = 4'd3;
    localparam logic [3:0] S_BIN_RD  = 4'd4;
    localparam logic [3:0] S_BIN_CMP = 4'd5;
    localparam logic [3:0] S_DEL_MV  = 4'd6;
    localparam logic [3:0] S_RD_WAIT = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]         r_state, n_state;
    t_req               r_req, n_req;
    logic [LW-1:0]      r_len, n_len;
    logic [AW-1:0]      r_idx, n_idx;
    logic [LW-1:0]      r_lo, n_lo;
    logic [LW-1:0]      r_hi, n_hi;
    logic [1:0]         r_status, n_status;
    logic [4:0]         r_fpos, n_fpos;
    logic signed [31:0] r_data, n_data;
    t_rsp               r_out, n_out;
    logic               r_out_vld, n_out_vld;

    // table memory: one write and one registered read per cycle
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rdata;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    // shared arithmetic
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    len_ext;
    logic [XW-1:0]      idx_inc1;
    logic [XW-1:0]      idx_inc2;
    logic [XW-1:0]      len_x;
    logic [XW-1:0]      mid_sum;
    logic [AW-1:0]      mid;
    logic [AW-1:0]      idx_dec;
    logic               load_out;

    assign pos_ext  = CMPW'(i_in_data.position);
    assign len_ext  = CMPW'(r_len);
    assign idx_inc1 = XW'(r_idx) + XW'(1);
    assign idx_inc2 = XW'(r_idx) + XW'(2);
    assign len_x    = XW'(r_len);
    assign mid_sum  = XW'(r_lo) + XW'(r_hi) - XW'(1);
    assign mid      = AW'(mid_sum >> 1);
    assign idx_dec  = r_idx - AW'(1);
    assign load_out = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_len     = r_len;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_status  = r_status;
        n_fpos    = r_fpos;
        n_data    = r_data;
        rd_addr   = '0;
        we        = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_data;
                    n_status = ST_OK;
                    n_fpos   = '0;
                    n_data   = '0;
                    n_state  = S_DONE;
                    unique case (i_in_data.operation)
                        OP_SEARCH: begin
                            if (r_len == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_LIN;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_ext > len_ext) begin
                                n_status = ST_BEYOND;
                            end else if (len_ext == CMPW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (pos_ext == len_ext) begin
                                n_state = S_INS_KEY;
                            end else begin
                                // start moving the top entry up by one
                                rd_addr = AW'(r_len) - AW'(1);
                                n_idx   = AW'(r_len);
                                n_state = S_INS_MV;
                            end
                        end
                        OP_UPDATE, OP_DELETE: begin
                            n_lo    = '0;
                            n_hi    = r_len;
                            n_state = S_BIN_RD;
                        end
                        OP_READ: begin
                            if (pos_ext >= len_ext) begin
                                n_status = ST_BEYOND;
                            end else begin
                                rd_addr = AW'(i_in_data.position);
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LIN: begin
                if (r_rdata == r_req.key_value) begin
                    n_fpos  = 5'(r_idx);
                    n_state = S_DONE;
                end else if (idx_inc1 == len_x) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = AW'(idx_inc1);
                    n_idx   = AW'(idx_inc1);
                end
            end
            S_INS_MV: begin
                we      = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rdata;
                if (idx_dec == AW'(r_req.position)) begin
                    n_state = S_INS_KEY;
                end else begin
                    rd_addr = r_idx - AW'(2);
                    n_idx   = idx_dec;
                end
            end
            S_INS_KEY: begin
                we      = 1'b1;
                wr_addr = AW'(r_req.position);
                wr_data = r_req.key_value;
                n_len   = r_len + LW'(1);
                n_fpos  = r_req.position[4:0];
                n_state = S_DONE;
            end
            S_BIN_RD: begin
                if (r_lo < r_hi) begin
                    rd_addr = mid;
                    n_idx   = mid;
                    n_state = S_BIN_CMP;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_BIN_CMP: begin
                if (r_rdata > r_req.key_value) begin
                    n_hi    = LW'(r_idx);
                    n_state = S_BIN_RD;
                end else if (r_rdata < r_req.key_value) begin
                    n_lo    = LW'(idx_inc1);
                    n_state = S_BIN_RD;
                end else begin
                    n_fpos = 5'(r_idx);
                    if (r_req.operation == OP_UPDATE) begin
                        we      = 1'b1;
                        wr_addr = r_idx;
                        wr_data = r_req.replacement;
                        n_state = S_DONE;
                    end else if (idx_inc1 == len_x) begin
                        n_len   = r_len - LW'(1);
                        n_state = S_DONE;
                    end else begin
                        // close the gap: pull the next entry down
                        rd_addr = AW'(idx_inc1);
                        n_state = S_DEL_MV;
                    end
                end
            end
            S_DEL_MV: begin
                we      = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rdata;
                if (idx_inc2 == len_x) begin
                    n_len   = r_len - LW'(1);
                    n_state = S_DONE;
                end else begin
                    rd_addr = AW'(idx_inc2);
                    n_idx   = AW'(idx_inc1);
                end
            end
            S_RD_WAIT: begin
                n_data  = r_rdata;
                n_fpos  = r_req.position[4:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: load the finished response, drop it once taken
    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out.status         = r_status;
            n_out.found_position = r_fpos;
            n_out.read_data      = r_data;
            n_out.entry_count    = 6'(r_len);
            n_out_vld            = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
        r_fpos   <= n_fpos;
        r_data   <= n_data;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // the count never passes the table size
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("entry count beyond capacity");

    // the count moves only as a request finishes
    a_len_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_len != $past(r_len))) |-> (r_state == S_DONE))
        else $error("entry count changed outside completion");

    // the table is written only while a request is in progress
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> ((r_state != S_IDLE) && (r_state != S_DONE)))
        else $error("table write while idle");

    // a full-table response is only given with the table at capacity
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && (r_status == ST_FULL)) |-> (r_len == LW'(CAPACITY)))
        else $error("full status with room left");

endmodule

`default_nettype wire
